// ===== design/sle_pkg.sv =====
`default_nettype none

package sle_pkg;

	localparam int CAPACITY = 16;
	localparam int VW       = 32;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = $clog2(CAPACITY + 1);

	typedef logic signed [VW-1:0] value_t;
	typedef logic [AW-1:0]        addr_t;
	typedef logic [CW-1:0]        count_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_PLACE,
		S_FWD,
		S_SRCH,
		S_EMIT
	} state_t;

	typedef struct packed {
		cmd_t         cmd;
		value_t       value_in;
		logic [3:0]   position_in;
	} in_item_t;

	typedef struct packed {
		status_t      status;
		value_t       value_out;
		logic [3:0]   position_out;
		logic [4:0]   count;
		logic         empty_res;
	} out_item_t;

	typedef struct packed {
		logic   we;
		addr_t  waddr;
		value_t wdata;
		addr_t  raddr;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== design/sorted_list_engine.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data (cmd, value_in, position_in)
// out       output     out_valid / out_ready  out_data (status, value_out, position_out,
//                                             count, empty_res)
// cfg       input      cfg_valid / cfg_ready  cfg_data (order_mode)
//
// Work runs one stored entry per cycle through the store and the one shared comparator:
// a read visits its position, a remove walks from there to the last entry, a search from
// the bottom to the match or the end, an insert over all entries then places the value;
// a refused item or a search of an empty store goes straight to its result.
// The input is ready only while the sequencer is idle.
// Reset clears the count and the order mode; the store itself is not cleared.
// A finished item waits in the output register while out_ready is low; the next item is
// taken meanwhile and held at its end until that register frees.

module sorted_list_engine (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  sle_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output sle_pkg::out_item_t  out_data,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire                 cfg_data
);

	logic               order_q;
	logic               out_valid_q;
	sle_pkg::out_item_t out_q;
	sle_pkg::mem_req_t  mem_req;
	sle_pkg::value_t    rd_data;
	logic               res_valid;
	logic               res_ready;
	sle_pkg::out_item_t res;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || out_ready;

	sle_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	sle_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.order_mode (order_q),
		.rd_data    (rd_data),
		.mem_req    (mem_req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				order_q <= cfg_data;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== design/sle_store.sv =====
`default_nettype none

module sle_store (
	input  wire                 clk,
	input  sle_pkg::mem_req_t   mem_req,
	output sle_pkg::value_t     rd_data
);

	sle_pkg::value_t mem_q [sle_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem_q[mem_req.waddr] <= mem_req.wdata;
		end
		rd_data <= mem_q[mem_req.raddr];
	end

endmodule

`default_nettype wire

// ===== design/sle_seq.sv =====
`default_nettype none

module sle_seq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  sle_pkg::in_item_t   in_data,
	input  wire                 order_mode,
	input  sle_pkg::value_t     rd_data,
	output sle_pkg::mem_req_t   mem_req,
	output logic                res_valid,
	input  wire                 res_ready,
	output sle_pkg::out_item_t  res
);

	sle_pkg::state_t  state_q, state_d;
	sle_pkg::addr_t   idx_q, idx_d;
	sle_pkg::count_t  count_q, count_d;
	sle_pkg::cmd_t    cmd_q;
	sle_pkg::value_t  val_q;
	sle_pkg::addr_t   pos_q;
	sle_pkg::status_t status_q, status_d;
	sle_pkg::value_t  vout_q, vout_d;
	sle_pkg::addr_t   posout_q, posout_d;
	sle_pkg::value_t  carry_q, carry_d;
	logic             shift_q, shift_d;

	logic            lt, eq, hold;
	logic            full, empty, pos_bad, fwd_last, srch_last;
	sle_pkg::addr_t  cnt_m1;

	// The single comparator shared by insert and search.
	assign lt   = rd_data < val_q;
	assign eq   = rd_data == val_q;
	assign hold = order_mode ? !lt : (lt || eq);

	assign full      = count_q == sle_pkg::count_t'(sle_pkg::CAPACITY);
	assign empty     = count_q == '0;
	assign cnt_m1    = sle_pkg::addr_t'(count_q - sle_pkg::count_t'(1));
	assign pos_bad   = {1'b0, in_data.position_in} >= count_q;
	assign fwd_last  = (cmd_q == sle_pkg::CMD_READ) || (idx_q == cnt_m1);
	assign srch_last = idx_q == cnt_m1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sle_pkg::S_IDLE: begin
				if (in_valid) begin
					case (in_data.cmd)
						sle_pkg::CMD_INSERT: begin
							if (full) begin
								state_d = sle_pkg::S_EMIT;
							end else if (empty) begin
								state_d = sle_pkg::S_PLACE;
							end else begin
								state_d = sle_pkg::S_INS;
							end
						end
						sle_pkg::CMD_REMOVE, sle_pkg::CMD_READ: begin
							state_d = pos_bad ? sle_pkg::S_EMIT : sle_pkg::S_FWD;
						end
						default: begin
							state_d = empty ? sle_pkg::S_EMIT : sle_pkg::S_SRCH;
						end
					endcase
				end
			end
			sle_pkg::S_INS: begin
				if (idx_q == cnt_m1) begin
					state_d = sle_pkg::S_PLACE;
				end
			end
			sle_pkg::S_PLACE: begin
				state_d = sle_pkg::S_EMIT;
			end
			sle_pkg::S_FWD: begin
				if (fwd_last) begin
					state_d = sle_pkg::S_EMIT;
				end
			end
			sle_pkg::S_SRCH: begin
				if (eq || srch_last) begin
					state_d = sle_pkg::S_EMIT;
				end
			end
			sle_pkg::S_EMIT: begin
				if (res_ready) begin
					state_d = sle_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sle_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = idx_q;
		mem_req.wdata = rd_data;
		mem_req.raddr = idx_q;
		idx_d         = idx_q;
		count_d       = count_q;
		status_d      = status_q;
		vout_d        = vout_q;
		posout_d      = posout_q;
		carry_d       = carry_q;
		shift_d       = shift_q;
		case (state_q)
			sle_pkg::S_IDLE: begin
				in_ready = 1'b1;
				case (in_data.cmd)
					sle_pkg::CMD_INSERT: mem_req.raddr = '0;
					sle_pkg::CMD_REMOVE, sle_pkg::CMD_READ: begin
						mem_req.raddr = in_data.position_in;
					end
					default: mem_req.raddr = '0;
				endcase
				if (in_valid) begin
					status_d = sle_pkg::ST_OK;
					vout_d   = '0;
					posout_d = '0;
					carry_d  = in_data.value_in;
					shift_d  = 1'b0;
					case (in_data.cmd)
						sle_pkg::CMD_INSERT: begin
							idx_d = '0;
							if (full) begin
								status_d = sle_pkg::ST_FULL;
							end
						end
						sle_pkg::CMD_REMOVE, sle_pkg::CMD_READ: begin
							idx_d = in_data.position_in;
							if (pos_bad) begin
								status_d = sle_pkg::ST_INVALID;
							end
						end
						default: begin
							idx_d = '0;
							if (empty) begin
								status_d = sle_pkg::ST_NOTFOUND;
							end
						end
					endcase
				end
			end
			sle_pkg::S_INS: begin
				// Walk up from the bottom; from the first entry that breaks the order on,
				// each entry is written one place higher.
				mem_req.raddr = idx_q + sle_pkg::addr_t'(1);
				mem_req.waddr = idx_q;
				mem_req.wdata = carry_q;
				if (shift_q || !hold) begin
					mem_req.we = 1'b1;
					carry_d    = rd_data;
					shift_d    = 1'b1;
				end
				idx_d = idx_q + sle_pkg::addr_t'(1);
			end
			sle_pkg::S_PLACE: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q;
				mem_req.wdata = carry_q;
				count_d       = count_q + sle_pkg::count_t'(1);
			end
			sle_pkg::S_FWD: begin
				// Walk up from the position; a remove moves each later entry down by one, a read stops there.
				mem_req.raddr = idx_q + sle_pkg::addr_t'(1);
				if (idx_q == pos_q) begin
					vout_d = rd_data;
				end else begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q - sle_pkg::addr_t'(1);
				end
				if (fwd_last) begin
					if (cmd_q == sle_pkg::CMD_REMOVE) begin
						count_d = count_q - sle_pkg::count_t'(1);
					end
				end else begin
					idx_d = idx_q + sle_pkg::addr_t'(1);
				end
			end
			sle_pkg::S_SRCH: begin
				mem_req.raddr = idx_q + sle_pkg::addr_t'(1);
				if (eq) begin
					posout_d = idx_q;
				end else if (srch_last) begin
					status_d = sle_pkg::ST_NOTFOUND;
				end else begin
					idx_d = idx_q + sle_pkg::addr_t'(1);
				end
			end
			sle_pkg::S_EMIT: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sle_pkg::S_IDLE;
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_q <= in_data.cmd;
			val_q <= in_data.value_in;
			pos_q <= in_data.position_in;
		end
		status_q <= status_d;
		vout_q   <= vout_d;
		posout_q <= posout_d;
		carry_q  <= carry_d;
		shift_q  <= shift_d;
	end

	assign res.status       = status_q;
	assign res.value_out    = vout_q;
	assign res.position_out = posout_q;
	assign res.count        = count_q;
	assign res.empty_res    = empty;

endmodule

`default_nettype wire

// ===== test/sorted_list_engine_tb.sv =====
module sorted_list_engine_tb;
	import sle_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	sorted_list_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	in_item_t queued_ops[$];
	out_item_t list_replies_due[$];
	out_item_t next_reply;

	value_t shadow_vals[CAPACITY];
	int shadow_len = 0;
	bit shadow_desc = 1'b0;

	int gen_len = 0;
	bit gen_filling = 1'b1;
	bit calm = 1'b0;
	bit failed = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;
	int cycle_count = 0;

	function automatic bit in_order(value_t a, value_t b);
		return shadow_desc ? (a >= b) : (a <= b);
	endfunction

	function automatic out_item_t apply_list_op(in_item_t op);
		out_item_t r;
		int k;
		int i;
		int p;
		r = '0;
		r.status = ST_OK;
		p = int'(op.position_in);
		case (op.cmd)
			CMD_INSERT: begin
				if (shadow_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					k = 0;
					while (k < shadow_len && in_order(shadow_vals[k], op.value_in))
						k++;
					for (i = shadow_len; i > k; i--)
						shadow_vals[i] = shadow_vals[i - 1];
					shadow_vals[k] = op.value_in;
					shadow_len++;
				end
			end
			CMD_REMOVE, CMD_READ: begin
				if (p >= shadow_len) begin
					r.status = ST_INVALID;
				end else begin
					r.value_out = shadow_vals[p];
					if (op.cmd == CMD_REMOVE) begin
						for (i = p; i + 1 < shadow_len; i++)
							shadow_vals[i] = shadow_vals[i + 1];
						shadow_len--;
					end
				end
			end
			default: begin
				r.status = ST_NOTFOUND;
				for (k = 0; k < shadow_len; k++) begin
					if (shadow_vals[k] == op.value_in) begin
						r.status = ST_OK;
						r.position_out = 4'(k);
						break;
					end
				end
			end
		endcase
		r.count = 5'(shadow_len);
		r.empty_res = (shadow_len == 0);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failed = 1'b1;
		end
	endtask

	function automatic value_t pick_value();
		value_t v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				v = $urandom_range(0, 8);
				v = v - 4;
			end
			4, 5: begin
				case ($urandom_range(0, 5))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h0;
					4: v = 32'h8000_0001;
					default: v = 32'h7FFF_FFFE;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic push_op(cmd_t c, value_t v, logic [3:0] p);
		in_item_t it;
		it.cmd = c;
		it.value_in = v;
		it.position_in = p;
		queued_ops.push_back(it);
		if (c == CMD_INSERT && gen_len < CAPACITY)
			gen_len++;
		if (c == CMD_REMOVE && int'(p) < gen_len)
			gen_len--;
		if (gen_len == CAPACITY)
			gen_filling = 1'b0;
		if (gen_len == 0)
			gen_filling = 1'b1;
	endtask

	task automatic push_random(int n);
		cmd_t c;
		int roll;
		logic [3:0] p;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				c = gen_filling ? CMD_INSERT : CMD_REMOVE;
			else if (roll < 70)
				c = gen_filling ? CMD_REMOVE : CMD_INSERT;
			else if (roll < 85)
				c = CMD_READ;
			else
				c = CMD_SEARCH;
			if ((c == CMD_REMOVE || c == CMD_READ) && gen_len > 0
					&& $urandom_range(0, 4) != 0)
				p = 4'($urandom_range(0, gen_len - 1));
			else
				p = 4'($urandom_range(0, 15));
			push_op(c, pick_value(), p);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (queued_ops.size() != 0 || in_valid || list_replies_due.size() != 0);
	endtask

	task automatic set_order(bit desc);
		repeat (20) @(posedge clk);
		cfg_data <= desc;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		shadow_desc = desc;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				list_replies_due.push_back(apply_list_op(in_data));
			if (!in_valid || in_ready) begin
				if (send_gap > 0 && !calm) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 18);
					in_valid <= 1'b0;
				end else if (queued_ops.size() != 0) begin
					in_data <= queued_ops.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (list_replies_due.size() == 0) begin
					$error("result with no item outstanding: %p", out_data);
					failed = 1'b1;
				end else begin
					next_reply = list_replies_due.pop_front();
					check_field("status", next_reply.status, out_data.status);
					check_field("value_out", next_reply.value_out, out_data.value_out);
					check_field("position_out", next_reply.position_out,
						out_data.position_out);
					check_field("count", next_reply.count, out_data.count);
					check_field("empty_res", next_reply.empty_res, out_data.empty_res);
				end
			end
			if (recv_stall > 0 && !calm) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				recv_stall = $urandom_range(0, 18);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_op(CMD_SEARCH, 32'sd5, 4'd0);
		push_op(CMD_READ, 32'sd0, 4'd0);
		push_op(CMD_REMOVE, 32'sd0, 4'd15);
		push_op(CMD_INSERT, 32'h7FFF_FFFF, 4'd0);
		push_op(CMD_INSERT, 32'h8000_0000, 4'd0);
		push_op(CMD_INSERT, 32'sd0, 4'd0);
		push_op(CMD_INSERT, -32'sd1, 4'd0);
		push_op(CMD_INSERT, 32'sd0, 4'd0);
		push_op(CMD_INSERT, 32'sd1, 4'd0);
		push_op(CMD_SEARCH, 32'sd0, 4'd0);
		push_op(CMD_SEARCH, 32'sd42, 4'd0);
		push_op(CMD_READ, 32'sd0, 4'd5);
		push_op(CMD_READ, 32'sd0, 4'd6);
		push_op(CMD_REMOVE, 32'sd0, 4'd0);
		while (gen_len < CAPACITY)
			push_op(CMD_INSERT, pick_value(), 4'($urandom_range(0, 15)));
		push_op(CMD_INSERT, 32'sd7, 4'd0);
		push_op(CMD_READ, 32'sd0, 4'd15);
		wait_idle();

		set_order(1'b1);
		@(negedge clk);
		push_random(400);
		wait_idle();
		set_order(1'b0);
		@(negedge clk);
		push_random(250);
		wait_idle();
		push_random(150);
		wait_idle();
		set_order(1'b1);
		@(negedge clk);
		push_random(350);
		wait_idle();
		set_order(1'b0);
		@(negedge clk);
		calm = 1'b1;
		push_random(250);
		wait_idle();

		repeat (40) @(posedge clk);
		if (failed)
			$display("*** FAILED ***");
		else
			$display("*** PASSED ***");
		$finish;
	end
endmodule

// ===== files.f =====
design/sle_pkg.sv
design/sle_store.sv
design/sle_seq.sv
design/sorted_list_engine.sv
test/sorted_list_engine_tb.sv
